// ===== rtl/htc_pkg.sv =====
`timescale 1ns / 1ps

package htc_pkg;

  localparam int FRAC_BITS_DEF = 8;

  // Configuration register map.
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_T0_DEG = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_T1_DEG = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_T0_RAW = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_T1_RAW = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_H0_RH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_H1_RH  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_H0_RAW = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_H1_RAW = 3'd7;

  localparam logic FUNC_TEMP = 1'b0;
  localparam logic FUNC_HUM  = 1'b1;

  // Divisor scale as a shift: 8 for temperature, 2 for humidity.
  localparam int SHIFT_TEMP = 3;
  localparam int SHIFT_HUM  = 1;

  localparam int RAW_W  = 16;
  localparam int SPAN_W = 17;
  localparam int DP_W   = 11;
  localparam int PT_W   = 10;
  localparam int PROD_W = 28;
  localparam int SUM_W  = 29;
  localparam int QUOT_W = 32;
  localparam int DIV_W  = 16;

  localparam int QDEPTH = 4;

  localparam logic [QUOT_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
  localparam logic [QUOT_W-1:0] SAT_MIN = 32'h8000_0000;

  // One classified sample waiting for the arithmetic pipeline.
  typedef struct packed {
    logic                     is_hum;
    logic                     zero;
    logic signed [DP_W-1:0]   dp;
    logic signed [SPAN_W-1:0] dr;
    logic signed [SPAN_W-1:0] span;
    logic [PT_W-1:0]          p0;
  } htc_op_t;

  typedef struct packed {
    logic zero;
    logic ovf;
    logic neg;
  } htc_flags_t;

endpackage

// ===== rtl/humidity_temp_calibration.sv =====
`timescale 1ns / 1ps
// A word accepted on in_ passes through the queue write, product stage, scaling stage,
// 32 divider stages and result register before it appears on out_.
// Throughput: one word per cycle while out_ is not stalled, set by the fully pipelined one-bit-per-stage divider.
// Reset: synchronous active-low rst_n clears the calibration registers to zero
// and empties the queue and pipeline; there is no clearing pass.
module humidity_temp_calibration #(
  parameter int FRAC_BITS = htc_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [htc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [htc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [15:0]                    in_tdata,  // [15:0] raw_sample
  input  logic                           in_tuser,  // [0] func
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [31:0]                    out_tdata, // [31:0] calibrated_value
  output logic                           out_tuser  // [0] divide_error
);
  import htc_pkg::*;

  htc_op_t front_op, head_op;
  logic    q_full, q_head_valid, q_pop;

  htc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .func       (in_tuser),
    .raw_sample (in_tdata),
    .op         (front_op)
  );

  assign in_tready = !q_full;

  htc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_tvalid),
    .push_op    (front_op),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_op    (head_op)
  );

  htc_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .op_valid  (q_head_valid),
    .op        (head_op),
    .op_pop    (q_pop),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res_value (out_tdata),
    .res_error (out_tuser)
  );

endmodule

// ===== rtl/htc_front.sv =====
`timescale 1ns / 1ps

module htc_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [htc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [htc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                          func,
  input  logic [htc_pkg::RAW_W-1:0]     raw_sample,
  output htc_pkg::htc_op_t              op
);
  import htc_pkg::*;

  logic [PT_W-1:0]  t0_deg_r, t1_deg_r;
  logic [RAW_W-1:0] t0_raw_r, t1_raw_r;
  logic [7:0]       h0_rh_r, h1_rh_r;
  logic [RAW_W-1:0] h0_raw_r, h1_raw_r;

  logic [PT_W-1:0]          p0, p1;
  logic signed [SPAN_W-1:0] r0, r1, raw;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t0_deg_r <= '0;
      t1_deg_r <= '0;
      t0_raw_r <= '0;
      t1_raw_r <= '0;
      h0_rh_r  <= '0;
      h1_rh_r  <= '0;
      h0_raw_r <= '0;
      h1_raw_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_T0_DEG: t0_deg_r <= cfg_data[PT_W-1:0];
        REG_T1_DEG: t1_deg_r <= cfg_data[PT_W-1:0];
        REG_T0_RAW: t0_raw_r <= cfg_data;
        REG_T1_RAW: t1_raw_r <= cfg_data;
        REG_H0_RH:  h0_rh_r  <= cfg_data[7:0];
        REG_H1_RH:  h1_rh_r  <= cfg_data[7:0];
        REG_H0_RAW: h0_raw_r <= cfg_data;
        REG_H1_RAW: h1_raw_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pick the calibration pair for the requested quantity and form the differences.
  always_comb begin
    if (func == FUNC_HUM) begin
      p0 = PT_W'(h0_rh_r);
      p1 = PT_W'(h1_rh_r);
      r0 = SPAN_W'($signed(h0_raw_r));
      r1 = SPAN_W'($signed(h1_raw_r));
    end else begin
      p0 = t0_deg_r;
      p1 = t1_deg_r;
      r0 = SPAN_W'($signed(t0_raw_r));
      r1 = SPAN_W'($signed(t1_raw_r));
    end
    raw       = SPAN_W'($signed(raw_sample));
    op.is_hum = (func == FUNC_HUM);
    op.dp     = $signed({1'b0, p1}) - $signed({1'b0, p0});
    op.dr     = raw - r0;
    op.span   = r1 - r0;
    op.zero   = (r1 == r0);
    op.p0     = p0;
  end

endmodule

// ===== rtl/htc_queue.sv =====
`timescale 1ns / 1ps

module htc_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  htc_pkg::htc_op_t push_op,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output htc_pkg::htc_op_t head_op
);
  import htc_pkg::*;

  localparam int PW = $clog2(QDEPTH);
  localparam int CW = $clog2(QDEPTH + 1);

  htc_op_t         mem_r [QDEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign full       = (cnt_r == CW'(QDEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_op    = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_op;
    end
  end

endmodule

// ===== rtl/htc_div.sv =====
`timescale 1ns / 1ps

module htc_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [htc_pkg::DIV_W-1:0]  in_rem,
  input  logic [htc_pkg::QUOT_W-1:0] in_word,
  input  logic [htc_pkg::DIV_W-1:0]  in_den,
  input  htc_pkg::htc_flags_t        in_flags,
  output logic                       out_valid,
  output logic [htc_pkg::QUOT_W-1:0] out_quot,
  output htc_pkg::htc_flags_t        out_flags
);
  import htc_pkg::*;

  localparam int STAGES = QUOT_W;

  // The word shifts dividend bits out at the top and quotient bits in at the bottom.
  logic               v_r   [STAGES];
  logic [DIV_W-1:0]   rem_r [STAGES];
  logic [QUOT_W-1:0]  w_r   [STAGES];
  logic [DIV_W-1:0]   den_r [STAGES];
  htc_flags_t         fl_r  [STAGES];

  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    logic              v_cur;
    logic [DIV_W-1:0]  rem_cur, den_cur, rem_nxt;
    logic [QUOT_W-1:0] w_cur;
    htc_flags_t        fl_cur;
    logic [DIV_W:0]    trial, diff;
    logic              ge;

    if (k == 0) begin : g_first
      assign v_cur   = in_valid;
      assign rem_cur = in_rem;
      assign w_cur   = in_word;
      assign den_cur = in_den;
      assign fl_cur  = in_flags;
    end else begin : g_next
      assign v_cur   = v_r[k-1];
      assign rem_cur = rem_r[k-1];
      assign w_cur   = w_r[k-1];
      assign den_cur = den_r[k-1];
      assign fl_cur  = fl_r[k-1];
    end

    assign trial   = {rem_cur, w_cur[QUOT_W-1]};
    assign diff    = trial - {1'b0, den_cur};
    assign ge      = (trial >= {1'b0, den_cur});
    assign rem_nxt = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_cur;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= rem_nxt;
        w_r[k]   <= {w_cur[QUOT_W-2:0], ge};
        den_r[k] <= den_cur;
        fl_r[k]  <= fl_cur;
      end
    end
  end

  assign out_valid = v_r[STAGES-1];
  assign out_quot  = w_r[STAGES-1];
  assign out_flags = fl_r[STAGES-1];

endmodule

// ===== rtl/htc_back.sv =====
`timescale 1ns / 1ps

module htc_back #(
  parameter int FRAC_BITS = htc_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       op_valid,
  input  htc_pkg::htc_op_t           op,
  output logic                       op_pop,
  output logic                       res_valid,
  input  logic                       res_ready,
  output logic [htc_pkg::QUOT_W-1:0] res_value,
  output logic                       res_error
);
  import htc_pkg::*;

  localparam int NUM_W = SUM_W + FRAC_BITS;
  localparam int NX    = (NUM_W > QUOT_W) ? NUM_W : QUOT_W + 1;
  localparam int HW    = NX - QUOT_W;
  localparam int CW    = (HW > DIV_W) ? HW : DIV_W;

  logic en;

  // Stage 1: products.
  logic                     s1_valid_r;
  logic signed [PROD_W-1:0] s1_m1_r, s1_m2_r;
  logic signed [SPAN_W-1:0] s1_span_r;
  logic                     s1_hum_r, s1_zero_r;

  // Stage 2: magnitudes, scaling and overflow check.
  logic                     s2_valid_r;
  logic [DIV_W-1:0]         s2_rem_r, s2_den_r;
  logic [QUOT_W-1:0]        s2_word_r;
  htc_flags_t               s2_flags_r;

  logic signed [SUM_W-1:0]  num;
  logic [SUM_W-1:0]         num_mag;
  logic [NUM_W-1:0]         scaled, shifted;
  logic [NX-1:0]            nx;
  logic [CW-1:0]            hi_ext, den_ext;
  logic [SPAN_W-1:0]        span_mag;
  htc_flags_t               s2_flags_nxt;

  logic                     dv_valid;
  logic [QUOT_W-1:0]        dv_quot;
  htc_flags_t               dv_flags;

  logic                     out_valid_r;
  logic [QUOT_W-1:0]        out_value_r, value_nxt;
  logic                     out_error_r;

  // The whole pipeline advances whenever the result register is free or being drained.
  assign en     = !out_valid_r || res_ready;
  assign op_pop = en && op_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r  <= op_valid;
      s2_valid_r  <= s1_valid_r;
      out_valid_r <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_m1_r   <= PROD_W'(op.dp * op.dr);
      s1_m2_r   <= PROD_W'(op.span * $signed({1'b0, op.p0}));
      s1_span_r <= op.span;
      s1_hum_r  <= op.is_hum;
      s1_zero_r <= op.zero;
    end
  end

  always_comb begin
    num      = SUM_W'(s1_m1_r) + SUM_W'(s1_m2_r);
    num_mag  = num[SUM_W-1] ? SUM_W'(-num) : SUM_W'(num);
    span_mag = s1_span_r[SPAN_W-1] ? SPAN_W'(-s1_span_r) : SPAN_W'(s1_span_r);
    scaled   = NUM_W'(num_mag) << FRAC_BITS;
    shifted  = s1_hum_r ? (scaled >> SHIFT_HUM) : (scaled >> SHIFT_TEMP);
    nx       = NX'(shifted);
    hi_ext   = CW'(nx[NX-1:QUOT_W]);
    den_ext  = CW'(span_mag[DIV_W-1:0]);
    s2_flags_nxt.zero = s1_zero_r;
    // A quotient of 2^32 or more cannot come out of the divider; it saturates instead.
    s2_flags_nxt.ovf  = (hi_ext >= den_ext);
    s2_flags_nxt.neg  = num[SUM_W-1] ^ s1_span_r[SPAN_W-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_rem_r   <= hi_ext[DIV_W-1:0];
      s2_word_r  <= nx[QUOT_W-1:0];
      s2_den_r   <= span_mag[DIV_W-1:0];
      s2_flags_r <= s2_flags_nxt;
    end
  end

  htc_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s2_valid_r),
    .in_rem    (s2_rem_r),
    .in_word   (s2_word_r),
    .in_den    (s2_den_r),
    .in_flags  (s2_flags_r),
    .out_valid (dv_valid),
    .out_quot  (dv_quot),
    .out_flags (dv_flags)
  );

  always_comb begin
    if (dv_flags.zero) begin
      value_nxt = '0;
    end else if (dv_flags.neg) begin
      value_nxt = (dv_flags.ovf || dv_quot > SAT_MIN) ? SAT_MIN : QUOT_W'(-dv_quot);
    end else begin
      value_nxt = (dv_flags.ovf || dv_quot[QUOT_W-1]) ? SAT_MAX : dv_quot;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_value_r <= value_nxt;
      out_error_r <= dv_flags.zero;
    end
  end

  assign res_valid = out_valid_r;
  assign res_value = out_value_r;
  assign res_error = out_error_r;

endmodule

// ===== tb/sv/calibration_checker.sv =====
`timescale 1ns / 1ps

module calibration_checker #(
  parameter int FRAC_BITS = htc_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [htc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [htc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [15:0]                    in_tdata,
  input  logic                           in_tuser,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [31:0]                    out_tdata,
  input  logic                           out_tuser,
  output int                             mismatches,
  output int                             pending,
  output int                             readings_checked,
  output int                             div_flags
);
  import htc_pkg::*;

  localparam int NUM_REGS = 1 << CFG_IDX_W;
  localparam longint VALUE_MAX = 64'sd2147483647;
  localparam longint VALUE_MIN = -64'sd2147483648;

  typedef struct packed {
    logic signed [31:0] value;
    logic               div_err;
  } reading_t;

  logic [CFG_DATA_W-1:0] cal [NUM_REGS];
  reading_t              expected_readings [$];
  int                    mism_n = 0;
  int                    checked_n = 0;
  int                    flag_n = 0;

  function automatic logic [CFG_DATA_W-1:0] reg_width_mask(logic [CFG_IDX_W-1:0] idx);
    case (idx)
      REG_T0_DEG, REG_T1_DEG: return 16'h03FF;
      REG_H0_RH, REG_H1_RH:   return 16'h00FF;
      default:                return 16'hFFFF;
    endcase
  endfunction

  // Exact rational interpolation, scaled to fixed point; 64-bit division
  // truncates toward zero, which is the rounding the block uses.
  function automatic reading_t calibrate(logic func, logic signed [RAW_W-1:0] raw);
    longint   p0, p1, r0, r1, scale, span, num, den, q;
    reading_t res;
    if (func == FUNC_HUM) begin
      p0 = longint'(cal[REG_H0_RH][7:0]);
      p1 = longint'(cal[REG_H1_RH][7:0]);
      r0 = longint'($signed(cal[REG_H0_RAW]));
      r1 = longint'($signed(cal[REG_H1_RAW]));
      scale = longint'(1) << SHIFT_HUM;
    end else begin
      p0 = longint'(cal[REG_T0_DEG][9:0]);
      p1 = longint'(cal[REG_T1_DEG][9:0]);
      r0 = longint'($signed(cal[REG_T0_RAW]));
      r1 = longint'($signed(cal[REG_T1_RAW]));
      scale = longint'(1) << SHIFT_TEMP;
    end
    span = r1 - r0;
    if (span == 0) begin
      res.value = '0;
      res.div_err = 1'b1;
      return res;
    end
    num = ((p1 - p0) * (longint'(raw) - r0) + span * p0) * (longint'(1) << FRAC_BITS);
    den = span * scale;
    q = num / den;
    if (q > VALUE_MAX) q = VALUE_MAX;
    else if (q < VALUE_MIN) q = VALUE_MIN;
    res.value = q[31:0];
    res.div_err = 1'b0;
    return res;
  endfunction

  always @(posedge clk) begin : watch
    reading_t want;
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) cal[i] = '0;
      expected_readings.delete();
    end else begin
      if (cfg_valid && cfg_ready) cal[cfg_index] = cfg_data & reg_width_mask(cfg_index);
      if (in_tvalid && in_tready) expected_readings.push_back(calibrate(in_tuser, in_tdata));
      if (out_tvalid && out_tready) begin
        checked_n++;
        if (out_tuser) flag_n++;
        if (expected_readings.size() == 0) begin
          $error("result word 0x%08h arrived with no sample waiting", out_tdata);
          mism_n++;
        end else begin
          want = expected_readings.pop_front();
          if (out_tdata !== want.value) begin
            $error("calibrated_value: expected %0d, got %0d", want.value, $signed(out_tdata));
            mism_n++;
          end
          if (out_tuser !== want.div_err) begin
            $error("divide_error: expected %0b, got %0b", want.div_err, out_tuser);
            mism_n++;
          end
        end
      end
    end
    pending <= expected_readings.size();
    mismatches <= mism_n;
    readings_checked <= checked_n;
    div_flags <= flag_n;
  end

endmodule

// ===== tb/sv/humidity_temp_calibration_test.sv =====
`timescale 1ns / 1ps

module humidity_temp_calibration_test;
  import htc_pkg::*;

  localparam int NUM_REGS = 1 << CFG_IDX_W;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_PHASES = 6;
  localparam int SAMPLES_PER_PHASE = 125;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [15:0]           in_tdata = '0;  // [15:0] raw_sample
  logic                  in_tuser = 1'b0; // [0] func
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [31:0]           out_tdata;      // [31:0] calibrated_value
  logic                  out_tuser;      // [0] divide_error

  int mismatches, pending, readings_checked, div_flags;
  int cycle_count = 0;
  int burst_left = 0;
  bit steady = 1'b0;
  int temp_sent = 0;
  int hum_sent = 0;
  int settings_used = 0;

  logic [CFG_DATA_W-1:0] settings [NUM_REGS];
  logic [15:0]           stall_pat = 16'hFFFF;
  logic [5:0]            stall_tick = '0;

  humidity_temp_calibration dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  calibration_checker chk (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .mismatches(mismatches), .pending(pending),
    .readings_checked(readings_checked), .div_flags(div_flags)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // The receiver rotates a stall pattern and picks a fresh one each time stall_tick wraps to zero;
  // about a quarter of the patterns never stall.
  always @(posedge clk) begin
    stall_tick <= stall_tick + 1'b1;
    if (stall_tick == '0) begin
      stall_pat <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
    end else begin
      stall_pat <= {stall_pat[0], stall_pat[15:1]};
    end
    out_tready <= stall_pat[0];
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_sample(input logic func, input logic [15:0] raw);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      gap = steady ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tdata <= raw;
    in_tuser <= func;
    in_tvalid <= 1'b1;
    if (func == FUNC_HUM) hum_sent++;
    else temp_sent++;
    do @(posedge clk); while (!in_tready);
  endtask

  // Lowers valid and waits until every expected word has come back.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic program_cal();
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_index <= i[CFG_IDX_W-1:0];
      cfg_data <= settings[i];
      cfg_valid <= 1'b1;
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [15:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h8000;
      3:       return 16'h7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Second raw point is sometimes equal to the first, sometimes just beside it.
  function automatic logic [15:0] pick_second_raw(logic [15:0] first);
    case ($urandom_range(0, 7))
      0:       return first;
      1:       return first + 16'($urandom_range(1, 4));
      2:       return first - 16'($urandom_range(1, 4));
      default: return pick_value();
    endcase
  endfunction

  task automatic random_settings();
    settings[REG_T0_DEG] = pick_value();
    settings[REG_T1_DEG] = pick_value();
    settings[REG_T0_RAW] = pick_value();
    settings[REG_T1_RAW] = pick_second_raw(settings[REG_T0_RAW]);
    settings[REG_H0_RH]  = pick_value();
    settings[REG_H1_RH]  = pick_value();
    settings[REG_H0_RAW] = pick_value();
    settings[REG_H1_RAW] = pick_second_raw(settings[REG_H0_RAW]);
  endtask

  task automatic random_sample();
    logic        func;
    logic [15:0] raw;
    func = $urandom_range(0, 1) ? FUNC_HUM : FUNC_TEMP;
    case ($urandom_range(0, 9))
      0:       raw = 16'h8000;
      1:       raw = 16'h7FFF;
      2:       raw = ((func == FUNC_HUM) ? settings[REG_H0_RAW] : settings[REG_T0_RAW])
                     + 16'($urandom_range(0, 6)) - 16'd3;
      default: raw = 16'($urandom);
    endcase
    send_sample(func, raw);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Straight after reset every raw point is zero, so both quantities flag.
    send_sample(FUNC_TEMP, 16'h0000);
    send_sample(FUNC_HUM, 16'h8000);
    drain();

    // Widest rising slope: unit raw span at the bottom of the raw range.
    settings[REG_T0_DEG] = 16'h0000;
    settings[REG_T1_DEG] = 16'h03FF;
    settings[REG_T0_RAW] = 16'h8000;
    settings[REG_T1_RAW] = 16'h8001;
    settings[REG_H0_RH]  = 16'h0000;
    settings[REG_H1_RH]  = 16'h00FF;
    settings[REG_H0_RAW] = 16'h8000;
    settings[REG_H1_RAW] = 16'h8001;
    program_cal();
    send_sample(FUNC_TEMP, 16'h7FFF);
    send_sample(FUNC_TEMP, 16'h8000);
    send_sample(FUNC_HUM, 16'h7FFF);
    send_sample(FUNC_HUM, 16'h8000);
    send_sample(FUNC_TEMP, 16'h0000);
    send_sample(FUNC_HUM, 16'h0001);
    drain();

    // Falling slopes with negative spans; upper register bits carry junk.
    settings[REG_T0_DEG] = 16'hFFFF;
    settings[REG_T1_DEG] = 16'hFC00;
    settings[REG_T0_RAW] = 16'h8001;
    settings[REG_T1_RAW] = 16'h8000;
    settings[REG_H0_RH]  = 16'hFFFF;
    settings[REG_H1_RH]  = 16'hFF00;
    settings[REG_H0_RAW] = 16'h7FFF;
    settings[REG_H1_RAW] = 16'h8000;
    program_cal();
    send_sample(FUNC_TEMP, 16'h7FFF);
    send_sample(FUNC_TEMP, 16'h8000);
    send_sample(FUNC_HUM, 16'h7FFF);
    send_sample(FUNC_HUM, 16'h8000);
    send_sample(FUNC_HUM, 16'h0000);
    send_sample(FUNC_TEMP, 16'hFFFF);
    drain();

    // Ordinary temperature points give negative fractions that must truncate
    // toward zero; humidity has equal raw points and must flag on its own.
    settings[REG_T0_DEG] = 16'd200;
    settings[REG_T1_DEG] = 16'd400;
    settings[REG_T0_RAW] = 16'd300;
    settings[REG_T1_RAW] = 16'hFD44;
    settings[REG_H0_RH]  = 16'd60;
    settings[REG_H1_RH]  = 16'd160;
    settings[REG_H0_RAW] = 16'd1234;
    settings[REG_H1_RAW] = 16'd1234;
    program_cal();
    send_sample(FUNC_TEMP, 16'd301);
    send_sample(FUNC_TEMP, 16'hFA00);
    send_sample(FUNC_TEMP, 16'd2777);
    send_sample(FUNC_HUM, 16'd1234);
    send_sample(FUNC_HUM, 16'h5555);
    send_sample(FUNC_TEMP, 16'hAAAA);
    drain();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      steady = (ph % 3 == 2);
      random_settings();
      program_cal();
      repeat (SAMPLES_PER_PHASE) random_sample();
      drain();
    end

    repeat (40) @(posedge clk);
    $display("Checked %0d calibrated words from %0d temperature and %0d humidity samples",
             readings_checked, temp_sent, hum_sent);
    $display("over %0d calibration settings; %0d words flagged equal raw points.",
             settings_used, div_flags);
    if (mismatches == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== humidity_temp_calibration.f =====
rtl/htc_pkg.sv
rtl/htc_front.sv
rtl/htc_queue.sv
rtl/htc_div.sv
rtl/htc_back.sv
rtl/humidity_temp_calibration.sv
tb/sv/calibration_checker.sv
tb/sv/humidity_temp_calibration_test.sv
